FILE: rtl/tfp_pkg.sv
// package for the timed flash pool: constants, types and command structs
package tfp_pkg;

  localparam int unsigned NumSlots = 24;
  localparam int unsigned SlotW = 5;

  localparam logic [1:0] ReqSpawn   = 2'd0;
  localparam logic [1:0] ReqTick    = 2'd1;
  localparam logic [1:0] ReqClear   = 2'd2;
  localparam logic [1:0] ReqIgnored = 2'd3;

  localparam logic RegLights   = 1'b0;
  localparam logic RegEndScale = 1'b1;

  localparam logic [15:0] EndScaleReset = 16'd36045;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StRead,
    StCheck,
    StDiv,
    StShrink,
    StFade,
    StEmit,
    StSpawn,
    StOut
  } state_e;

  typedef struct packed {
    logic       load_req;
    logic       clr_scan;
    logic       inc_scan;
    logic       rd_en;
    logic       div_start;
    logic       do_shrink;
    logic       do_fade;
    logic       emit_tick;
    logic       do_spawn;
    logic       do_clear;
    logic       set_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       scan_done;
    logic       cur_valid;
    logic       expire;
    logic       div_busy;
    logic       reject;
    logic       any_after;
  } sts_t;

  typedef struct packed {
    logic [SlotW-1:0] slot_index;
    logic [15:0]      cur_radius;
    logic [7:0]       cur_red;
    logic [7:0]       cur_green;
    logic [7:0]       cur_blue;
    logic             expired;
    logic             first_report;
    logic             evicted;
    logic             rejected;
    logic             last;
  } result_t;

endpackage

FILE: rtl/tfp_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
module tfp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/tfp_div.sv
// serial restoring divider: frac = min(65535, (el << 16) / dur)
module tfp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] el_i,
  input  logic [31:0] dur_i,
  output logic        busy_o,
  output logic [15:0] frac_o
);
  logic [47:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dur_q, dur_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    dur_d  = dur_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[31:0], num_q[47]};
    if (start_i) begin
      num_d  = {el_i, 16'd0};
      rem_d  = '0;
      dur_d  = dur_i;
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dur_q}) begin
        rem_d = trial - {1'b0, dur_q};
        num_d = {num_q[46:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dur_q <= dur_d;
  end

  assign busy_o = busy_q;
  assign frac_o = (num_q[47:16] != 32'd0) ? 16'hFFFF : num_q[15:0];
endmodule

FILE: rtl/tfp_ctrl.sv
// controller state machine for spawn, tick and clear sequences
module tfp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic          out_busy_i,
  input  tfp_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output tfp_pkg::cmd_t cmd_o,
  output logic          out_load_o
);
  tfp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfp_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      tfp_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.clr_scan = 1'b1;
          state_d = tfp_pkg::StScan;
        end
      end
      tfp_pkg::StScan: begin
        case (sts_i.req)
          tfp_pkg::ReqSpawn: begin
            if (sts_i.reject) begin
              state_d = tfp_pkg::StOut;
            end else if (sts_i.scan_done) begin
              state_d = tfp_pkg::StSpawn;
            end else begin
              cmd_o.inc_scan = 1'b1;
            end
          end
          tfp_pkg::ReqTick: begin
            if (sts_i.scan_done) begin
              state_d = tfp_pkg::StIdle;
            end else if (sts_i.cur_valid) begin
              cmd_o.rd_en = 1'b1;
              state_d = tfp_pkg::StRead;
            end else begin
              cmd_o.inc_scan = 1'b1;
            end
          end
          tfp_pkg::ReqClear: begin
            cmd_o.do_clear = 1'b1;
            state_d = tfp_pkg::StIdle;
          end
          default: state_d = tfp_pkg::StIdle;
        endcase
      end
      tfp_pkg::StRead: state_d = tfp_pkg::StCheck;
      tfp_pkg::StCheck: begin
        if (sts_i.expire) begin
          state_d = tfp_pkg::StEmit;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = tfp_pkg::StDiv;
        end
      end
      tfp_pkg::StDiv: begin
        if (!sts_i.div_busy) begin
          cmd_o.do_shrink = 1'b1;
          state_d = tfp_pkg::StShrink;
        end
      end
      tfp_pkg::StShrink: begin
        cmd_o.do_fade = 1'b1;
        state_d = tfp_pkg::StFade;
      end
      tfp_pkg::StFade: state_d = tfp_pkg::StEmit;
      tfp_pkg::StEmit: begin
        if (!out_busy_i) begin
          cmd_o.emit_tick = 1'b1;
          cmd_o.set_last = !sts_i.any_after;
          cmd_o.inc_scan = 1'b1;
          out_load_o = 1'b1;
          state_d = tfp_pkg::StScan;
        end
      end
      tfp_pkg::StSpawn: begin
        if (!out_busy_i) begin
          cmd_o.do_spawn = 1'b1;
          out_load_o = 1'b1;
          state_d = tfp_pkg::StIdle;
        end
      end
      tfp_pkg::StOut: begin
        if (!out_busy_i) begin
          out_load_o = 1'b1;
          state_d = tfp_pkg::StIdle;
        end
      end
      default: state_d = tfp_pkg::StIdle;
    endcase
  end
endmodule

FILE: rtl/tfp_dp.sv
// datapath: slot stores, allocation scan, fade arithmetic and result register
module tfp_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic [1:0]        req_type_i,
  input  logic [31:0]       now_ms_i,
  input  logic [15:0]       start_radius_i,
  input  logic [7:0]        color_red_i,
  input  logic [7:0]        color_green_i,
  input  logic [7:0]        color_blue_i,
  input  logic [15:0]       duration_ms_i,
  input  tfp_pkg::cmd_t     cmd_i,
  input  logic              out_load_i,
  output tfp_pkg::sts_t     sts_o,
  output tfp_pkg::result_t  res_o
);
  localparam int unsigned SW = tfp_pkg::SlotW;
  localparam int unsigned N  = tfp_pkg::NumSlots;

  logic        lights_q;
  logic [15:0] end_scale_q;
  logic [N-1:0] valid_q, rep_q;

  logic [1:0]  req_q;
  logic [31:0] now_q;
  logic [15:0] rad_in_q, dur_in_q;
  logic [23:0] col_in_q;

  logic [SW:0]   scan_q;
  logic [SW-1:0] idx;
  logic [SW-1:0] pick_q;
  logic          found_q;
  logic          ev_found_q;
  logic [31:0]   best_q;
  logic [31:0]   key;
  logic          in_range;
  logic          free_hit;
  logic          ev_hit;

  logic [31:0] st_rd, et_rd;
  logic [15:0] rad_rd;
  logic [23:0] col_rd;
  logic [31:0] spawn_end;
  logic [31:0] past_end;
  logic        mem_we;

  logic [31:0] el, dur;
  logic        div_busy;
  logic [15:0] div_frac;
  logic [15:0] frac_q;
  logic [15:0] shrink_q;
  logic [15:0] rad_out_q;
  logic [7:0]  r_q, g_q, b_q;
  logic        expire_q;
  logic [N-1:0] after_mask;

  logic [16:0] one_minus_es, one_minus_fr, one_minus_sh;
  logic [32:0] shrink_prod;
  logic [32:0] rad_prod;
  logic [24:0] r_prod, g_prod, b_prod;

  tfp_pkg::result_t res_q;

  assign idx       = scan_q[SW-1:0];
  assign spawn_end = now_q + {16'd0, dur_in_q};
  assign past_end  = now_q - et_rd;
  assign mem_we    = cmd_i.do_spawn;
  assign key       = (et_rd - now_q) ^ 32'h8000_0000;

  tfp_ram #(.Width(32), .Depth(N)) u_st (
    .clk_i, .we_i(mem_we), .waddr_i(pick_q), .wdata_i(now_q),
    .raddr_i(idx), .rdata_o(st_rd));
  tfp_ram #(.Width(32), .Depth(N)) u_et (
    .clk_i, .we_i(mem_we), .waddr_i(pick_q), .wdata_i(spawn_end),
    .raddr_i(idx), .rdata_o(et_rd));
  tfp_ram #(.Width(16), .Depth(N)) u_rad (
    .clk_i, .we_i(mem_we), .waddr_i(pick_q), .wdata_i(rad_in_q),
    .raddr_i(idx), .rdata_o(rad_rd));
  tfp_ram #(.Width(24), .Depth(N)) u_col (
    .clk_i, .we_i(mem_we), .waddr_i(pick_q), .wdata_i(col_in_q),
    .raddr_i(idx), .rdata_o(col_rd));

  assign el  = now_q - st_rd;
  assign dur = et_rd - st_rd;

  tfp_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start && !el[31] && dur != 32'd0),
    .el_i(el), .dur_i(dur), .busy_o(div_busy), .frac_o(div_frac));

  // eviction scan reads one slot per pass, using a registered copy of the index
  logic        ev_chk_q;
  logic [SW-1:0] ev_idx_q;

  // a free slot always wins over an eviction candidate
  assign in_range = scan_q < (SW+1)'(N);
  assign free_hit = cmd_i.inc_scan && req_q == tfp_pkg::ReqSpawn && in_range
                    && !found_q && !valid_q[idx];
  assign ev_hit   = req_q == tfp_pkg::ReqSpawn && ev_chk_q && !found_q
                    && valid_q[ev_idx_q] && (!ev_found_q || key < best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lights_q    <= 1'b1;
      end_scale_q <= tfp_pkg::EndScaleReset;
      valid_q     <= '0;
      rep_q       <= '0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      ev_found_q  <= 1'b0;
      ev_chk_q    <= 1'b0;
      res_q       <= '0;
      req_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == tfp_pkg::RegLights) lights_q <= cfg_data_i[0];
        else end_scale_q <= cfg_data_i;
      end
      if (cmd_i.load_req) req_q <= req_type_i;
      if (cmd_i.clr_scan) begin
        scan_q     <= '0;
        found_q    <= 1'b0;
        ev_found_q <= 1'b0;
        ev_chk_q   <= 1'b0;
      end else if (cmd_i.inc_scan) begin
        scan_q <= scan_q + 1'b1;
        if (req_q == tfp_pkg::ReqSpawn) begin
          ev_chk_q <= in_range;
          ev_idx_q <= idx;
        end
      end else begin
        ev_chk_q <= 1'b0;
      end
      if (free_hit) begin
        found_q <= 1'b1;
        pick_q  <= idx;
      end else if (ev_hit) begin
        ev_found_q <= 1'b1;
        pick_q     <= ev_idx_q;
        best_q     <= key;
      end
      if (cmd_i.do_clear) begin
        valid_q <= '0;
        rep_q   <= '0;
      end
      if (cmd_i.do_spawn) begin
        valid_q[pick_q] <= 1'b1;
        rep_q[pick_q]   <= 1'b0;
      end
      if (cmd_i.emit_tick) begin
        if (expire_q) begin
          valid_q[idx] <= 1'b0;
          rep_q[idx]   <= 1'b0;
        end else begin
          rep_q[idx] <= 1'b1;
        end
      end
      if (out_load_i) begin
        res_q <= '0;
        if (req_q == tfp_pkg::ReqSpawn) begin
          res_q.last <= 1'b1;
          if (sts_o.reject) begin
            res_q.rejected <= 1'b1;
          end else begin
            res_q.slot_index <= pick_q;
            res_q.cur_radius <= rad_in_q;
            res_q.cur_red    <= col_in_q[23:16];
            res_q.cur_green  <= col_in_q[15:8];
            res_q.cur_blue   <= col_in_q[7:0];
            res_q.evicted    <= valid_q[pick_q];
          end
        end else begin
          res_q.slot_index <= idx;
          res_q.last       <= cmd_i.set_last;
          if (expire_q) begin
            res_q.expired <= 1'b1;
          end else begin
            res_q.cur_radius   <= rad_out_q;
            res_q.cur_red      <= r_q;
            res_q.cur_green    <= g_q;
            res_q.cur_blue     <= b_q;
            res_q.first_report <= !rep_q[idx];
          end
        end
      end
    end
  end

  assign one_minus_es = 17'h10000 - {1'b0, end_scale_q};
  assign one_minus_fr = 17'h10000 - {1'b0, frac_q};
  assign one_minus_sh = 17'h10000 - {1'b0, shrink_q};
  assign shrink_prod  = {1'b0, frac_q} * {16'd0, one_minus_es};
  assign rad_prod     = {1'b0, rad_rd} * {16'd0, one_minus_sh};
  assign r_prod       = col_rd[23:16] * one_minus_fr;
  assign g_prod       = col_rd[15:8] * one_minus_fr;
  assign b_prod       = col_rd[7:0] * one_minus_fr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      now_q    <= now_ms_i;
      rad_in_q <= start_radius_i;
      dur_in_q <= duration_ms_i;
      col_in_q <= {color_red_i, color_green_i, color_blue_i};
    end
    if (cmd_i.rd_en) begin
      frac_q <= '0;
    end
    expire_q <= !lights_q || !past_end[31];
    if (cmd_i.do_shrink) begin
      frac_q   <= (el[31] || dur == 32'd0) ? 16'd0 : div_frac;
    end
    if (cmd_i.do_fade) begin
      shrink_q <= shrink_prod[31:16];
    end
  end

  // final products computed the cycle after shrink is registered
  always_ff @(posedge clk_i) begin
    rad_out_q <= rad_prod[31:16];
    r_q       <= r_prod[23:16];
    g_q       <= g_prod[23:16];
    b_q       <= b_prod[23:16];
  end

  always_comb begin
    after_mask = '0;
    for (int k = 0; k < N; k++) begin
      after_mask[k] = (k > int'(idx)) && valid_q[k];
    end
  end

  assign sts_o.req       = req_q;
  assign sts_o.scan_done = (req_q == tfp_pkg::ReqSpawn)
                           ? (scan_q == (SW+1)'(N + 1) || found_q)
                           : (scan_q == (SW+1)'(N));
  assign sts_o.cur_valid = (scan_q < (SW+1)'(N)) && valid_q[idx];
  assign sts_o.expire    = !lights_q || !past_end[31];
  assign sts_o.div_busy  = div_busy;
  assign sts_o.reject    = rad_in_q == 16'd0 || dur_in_q == 16'd0 || !lights_q;
  assign sts_o.any_after = |after_mask;
  assign res_o           = res_q;
endmodule

FILE: rtl/timed_flash_pool_with_fade.sv
// Pool of 24 timed fading flash slots. A spawn scans for a free slot and, when
// the pool is full, picks an eviction candidate (one slot read a cycle); a
// refused spawn skips the scan. A tick steps over empty slots, reports expired
// slots directly and runs live slots through the 48-step serial divider that
// forms the fade fraction; a clear empties all slots. One request is worked at a
// time; each result waits in a single output register until transferred.
module timed_flash_pool_with_fade (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0], now_ms[33:2], start_radius[49:34], color_red[57:50],
  // color_green[65:58], color_blue[73:66], duration_ms[89:74], zero fill
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_index[4:0], cur_radius[20:5], cur_red[28:21], cur_green[36:29],
  // cur_blue[44:37], zero fill
  output logic [47:0] m_axis_tdata,
  // expired[0], first_report[1], evicted[2], rejected[3]
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  tfp_pkg::cmd_t    cmd;
  tfp_pkg::sts_t    sts;
  tfp_pkg::result_t res;
  logic             out_load;
  logic             out_valid_q;
  logic             busy;

  assign busy = out_valid_q && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  tfp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready),
    .out_busy_i(busy), .sts_i(sts),
    .in_ready_o(s_axis_tready), .cmd_o(cmd), .out_load_o(out_load));

  tfp_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_type_i(s_axis_tdata[1:0]), .now_ms_i(s_axis_tdata[33:2]),
    .start_radius_i(s_axis_tdata[49:34]), .color_red_i(s_axis_tdata[57:50]),
    .color_green_i(s_axis_tdata[65:58]), .color_blue_i(s_axis_tdata[73:66]),
    .duration_ms_i(s_axis_tdata[89:74]),
    .cmd_i(cmd), .out_load_i(out_load), .sts_o(sts), .res_o(res));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, res.cur_blue, res.cur_green, res.cur_red,
                          res.cur_radius, res.slot_index};
  assign m_axis_tuser  = {res.rejected, res.evicted, res.first_report, res.expired};
  assign m_axis_tlast  = res.last;
endmodule
